### rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants for the chained hash map: request actions, response
// status codes and parameter defaults.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int DEF_BUCKETS = 64;
   localparam int DEF_NODES   = 256;

   localparam logic [1:0] ACT_SET    = 2'd0;
   localparam logic [1:0] ACT_GET    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

endpackage

### rtl/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/chained_hash_map.sv
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-value map with separate chaining over a fixed node pool.
//
// A request (req_action, req_key, req_value) is taken when start is high and
// busy is low. Exactly one response follows, shown for one cycle with
// rsp_valid high; the receiver cannot stall it. busy stays high while a
// request is worked on, and a new request may be given in the response cycle.
// The bucket is the key modulo BUCKETS. Bucket heads, node keys, node values
// and node links each sit in a RAM with registered read data; the chain is
// walked one node per RAM read.
// A clear is answered in the cycle after it is taken and busy does not rise.
// Other actions pass through hashing (a mask for a power-of-two BUCKETS,
// else the key reduced one byte per cycle), a head read and one compare per
// node; a hit remove adds the S_REM step, an append to the chain adds S_MISS,
// S_ALLOC and S_LINK, any other miss adds S_MISS. The response shows in the
// first cycle with busy low.
// Reset and clear empty every bucket through per-bucket valid bits and
// rebuild the free list by zeroing a fill count of nodes used since then.
// ----------------------------------------------------------------------------
module chained_hash_map #(
   parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
   parameter int NODES   = chm_pkg::DEF_NODES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_found_value,
   output logic [8:0]  rsp_entry_total
);

   localparam int BW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int AW   = NODES > 1 ? $clog2(NODES) : 1;
   localparam int NW   = $clog2(NODES + 1);
   localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam logic [NW-1:0] NIL = NW'(NODES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_HEAD  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_MISS  = 3'd4;
   localparam logic [2:0] S_ALLOC = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;
   localparam logic [2:0] S_REM   = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  act_ff, act_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] hkey_ff, hkey_in;
   logic [BW:0] rem_ff, rem_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] prev_ff, prev_in;
   logic [NW-1:0] steps_ff, steps_in;
   logic [NW-1:0] free_ff, free_in;
   logic [NW-1:0] count_ff, count_in;
   logic [AW-1:0] new_ff, new_in;
   logic [AW-1:0] raddr_ff;
   logic [BUCKETS-1:0] hv_ff, hv_in;
   logic [NW-1:0]      fill_ff, fill_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_found_ff, rsp_found_in;

   logic [BW-1:0] head_raddr, head_waddr;
   logic          head_we;
   logic [NW-1:0] head_wdata, head_q, head_val;
   logic [AW-1:0] node_raddr, link_waddr, kv_waddr;
   logic          link_we, key_we, val_we;
   logic [NW-1:0] link_wdata, link_q, link_val;
   logic [63:0]   val_wdata, key_q, val_q;
   logic [BW:0]   rem_step;
   logic [BW:0]   rem_t;
   logic [NW-1:0] steps_nx;

   chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
      .rd_addr(head_raddr), .rd_data(head_q));
   chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(node_raddr), .rd_data(link_q));
   chm_ram #(.WIDTH(64), .DEPTH(NODES)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(kv_waddr), .wr_data(key_ff),
      .rd_addr(node_raddr), .rd_data(key_q));
   chm_ram #(.WIDTH(64), .DEPTH(NODES)) u_value (
      .clock(clock), .wr_en(val_we), .wr_addr(kv_waddr), .wr_data(val_wdata),
      .rd_addr(node_raddr), .rd_data(val_q));

   // entries never written since clear read as their reset contents
   assign head_val = hv_ff[bucket_ff] ? head_q : NIL;
   assign link_val = (NW'(raddr_ff) < fill_ff) ? link_q : NW'(raddr_ff) + NW'(1);
   assign steps_nx = steps_ff + NW'(1);

   // one key byte per cycle, remainder kept below BUCKETS
   always_comb begin
      rem_step = rem_ff;
      for (int i = 0; i < 8; i++) begin
         rem_t = {rem_step[BW-1:0], hkey_ff[63-i]};
         if (rem_t >= (BW+1)'(BUCKETS)) begin
            rem_t = rem_t - (BW+1)'(BUCKETS);
         end
         rem_step = rem_t;
      end
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      key_in = key_ff;
      val_in = val_ff;
      hkey_in = hkey_ff;
      rem_in = rem_ff;
      hcnt_in = hcnt_ff;
      bucket_in = bucket_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      free_in = free_ff;
      count_in = count_ff;
      new_in = new_ff;
      hv_in = hv_ff;
      fill_in = fill_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in = rsp_found_ff;
      head_raddr = bucket_ff;
      head_we = 1'b0;
      head_waddr = bucket_ff;
      head_wdata = NIL;
      node_raddr = cur_ff[AW-1:0];
      link_we = 1'b0;
      link_waddr = cur_ff[AW-1:0];
      link_wdata = NIL;
      key_we = 1'b0;
      val_we = 1'b0;
      kv_waddr = cur_ff[AW-1:0];
      val_wdata = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = req_action;
               key_in = req_key;
               val_in = req_value;
               hkey_in = req_key;
               rem_in = '0;
               hcnt_in = '0;
               if (req_action == chm_pkg::ACT_CLEAR) begin
                  hv_in = '0;
                  fill_in = '0;
                  free_in = '0;
                  count_in = '0;
                  rsp_valid_in = 1'b1;
                  rsp_status_in = chm_pkg::STAT_OK;
                  rsp_found_in = '0;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (POW2) begin
               bucket_in = BW'(key_ff & 64'(BUCKETS - 1));
               head_raddr = bucket_in;
               state_in = S_HEAD;
            end else begin
               rem_in = rem_step;
               hkey_in = hkey_ff << 8;
               hcnt_in = hcnt_ff + 3'd1;
               if (hcnt_ff == 3'd7) begin
                  bucket_in = rem_step[BW-1:0];
                  head_raddr = bucket_in;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            cur_in = head_val;
            prev_in = NIL;
            steps_in = '0;
            node_raddr = head_val[AW-1:0];
            state_in = (head_val >= NIL) ? S_MISS : S_CMP;
         end
         S_CMP: begin
            if (key_q == key_ff) begin
               unique case (act_ff)
                  chm_pkg::ACT_GET: begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = chm_pkg::STAT_OK;
                     rsp_found_in = val_q;
                     state_in = S_IDLE;
                  end
                  chm_pkg::ACT_REMOVE: begin
                     if (prev_ff >= NIL) begin
                        head_we = 1'b1;
                        head_wdata = link_val;
                        hv_in[bucket_ff] = 1'b1;
                     end else begin
                        link_we = 1'b1;
                        link_waddr = prev_ff[AW-1:0];
                        link_wdata = link_val;
                     end
                     state_in = S_REM;
                  end
                  default: begin
                     val_we = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_status_in = chm_pkg::STAT_OK;
                     rsp_found_in = '0;
                     state_in = S_IDLE;
                  end
               endcase
            end else begin
               prev_in = cur_ff;
               cur_in = link_val;
               steps_in = steps_nx;
               node_raddr = link_val[AW-1:0];
               if (link_val >= NIL || steps_nx == NIL) begin
                  state_in = S_MISS;
               end
            end
         end
         S_MISS: begin
            node_raddr = free_ff[AW-1:0];
            rsp_found_in = '0;
            if (act_ff != chm_pkg::ACT_SET) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = chm_pkg::STAT_NOT_FOUND;
               state_in = S_IDLE;
            end else if (free_ff >= NIL) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = chm_pkg::STAT_FULL;
               state_in = S_IDLE;
            end else begin
               new_in = free_ff[AW-1:0];
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            free_in = link_val;
            kv_waddr = new_ff;
            key_we = 1'b1;
            val_we = 1'b1;
            link_we = 1'b1;
            link_waddr = new_ff;
            link_wdata = NIL;
            if (NW'(new_ff) == fill_ff) begin
               fill_in = fill_ff + NW'(1);
            end
            state_in = S_LINK;
         end
         S_LINK: begin
            if (prev_ff >= NIL) begin
               head_we = 1'b1;
               head_wdata = NW'(new_ff);
               hv_in[bucket_ff] = 1'b1;
            end else begin
               link_we = 1'b1;
               link_waddr = prev_ff[AW-1:0];
               link_wdata = NW'(new_ff);
            end
            count_in = count_ff + NW'(1);
            rsp_valid_in = 1'b1;
            rsp_status_in = chm_pkg::STAT_OK;
            state_in = S_IDLE;
         end
         default: begin
            // remove: hit node goes back to the head of the free list
            link_we = 1'b1;
            link_wdata = free_ff;
            free_in = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - NW'(1);
            end
            rsp_valid_in = 1'b1;
            rsp_status_in = chm_pkg::STAT_OK;
            rsp_found_in = '0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff <= '0;
         count_ff <= '0;
         hv_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff <= free_in;
         count_ff <= count_in;
         hv_ff <= hv_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      key_ff <= key_in;
      val_ff <= val_in;
      hkey_ff <= hkey_in;
      rem_ff <= rem_in;
      hcnt_ff <= hcnt_in;
      bucket_ff <= bucket_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      new_ff <= new_in;
      raddr_ff <= node_raddr;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_total = 9'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL)
      else $error("entry count above pool size");

   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("request finished without response");

   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted request dropped");

   a_full_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == chm_pkg::STAT_FULL |-> free_ff >= NIL)
      else $error("full reported with free nodes left");

endmodule
